@@ sv/clcd_pkg.sv @@
// Shared constants, control word type and microcode ROM for the LCD bus write sequencer.
package clcd_pkg;

   // Cursor columns at or beyond this value saturate to the last column.
   localparam int unsigned LINE_LENGTH = 40;
   localparam int unsigned COL_W = 6;
   localparam logic [COL_W-1:0] COL_MAX = COL_W'(LINE_LENGTH - 1);

   // Request commands.
   localparam logic [1:0] CMD_INSTR  = 2'd0;
   localparam logic [1:0] CMD_DATA   = 2'd1;
   localparam logic [1:0] CMD_CURSOR = 2'd2;
   localparam logic [1:0] CMD_INIT   = 2'd3;

   // Configuration register indexes.
   localparam logic REG_BUS_MODE = 1'b0;
   localparam logic REG_DRIVE_RW = 1'b1;

   // Controller instruction bytes and nibbles.
   localparam logic [7:0] LCD_NIB_FUNC4   = 8'h02;
   localparam logic [7:0] LCD_NIB_LINES   = 8'h08;
   localparam logic [7:0] LCD_FUNC_SET8   = 8'h38;
   localparam logic [7:0] LCD_DISPLAY_ON  = 8'h0C;
   localparam logic [7:0] LCD_CLEAR       = 8'h01;

   // Microcode step addresses.
   localparam int unsigned STEP_W = 4;
   localparam logic [STEP_W-1:0] ENTRY_BYTE  = 4'd0;
   localparam logic [STEP_W-1:0] ENTRY_INIT4 = 4'd2;
   localparam logic [STEP_W-1:0] ENTRY_INIT8 = 4'd5;
   localparam logic [STEP_W-1:0] STEP_LAST   = 4'd9;

   // Byte source.
   localparam logic SRC_OPER  = 1'b0;
   localparam logic SRC_CONST = 1'b1;

   // Which part of the byte goes on the bus.
   localparam logic [1:0] PART_FULL = 2'd0;  // whole byte in either mode
   localparam logic [1:0] PART_HEAD = 2'd1;  // whole byte on 8-bit bus, high nibble on 4-bit bus
   localparam logic [1:0] PART_LOW  = 2'd2;  // low nibble

   // Conditions for the last flag and for jumps.
   localparam logic [1:0] COND_NEVER  = 2'd0;
   localparam logic [1:0] COND_ALWAYS = 2'd1;
   localparam logic [1:0] COND_IF_8BIT = 2'd2;

   typedef struct packed {
      logic              src;
      logic [7:0]        konst;
      logic [1:0]        part;
      logic [1:0]        last_cond;
      logic [1:0]        jump_cond;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   function automatic ctrl_word_type ctrl_rom(input logic [STEP_W-1:0] addr);
      ctrl_word_type w;
      w = '{src: SRC_CONST, konst: 8'h00, part: PART_FULL, last_cond: COND_ALWAYS,
            jump_cond: COND_NEVER, target: ENTRY_BYTE};
      case (addr)
         // Single byte: operand as one strobe or two nibbles.
         4'd0: w = '{SRC_OPER, 8'h00, PART_HEAD, COND_IF_8BIT, COND_NEVER, ENTRY_BYTE};
         4'd1: w = '{SRC_OPER, 8'h00, PART_LOW, COND_ALWAYS, COND_NEVER, ENTRY_BYTE};
         // Init on the 4-bit bus opens with raw nibbles.
         4'd2: w = '{SRC_CONST, LCD_NIB_FUNC4, PART_FULL, COND_NEVER, COND_NEVER, ENTRY_BYTE};
         4'd3: w = '{SRC_CONST, LCD_NIB_FUNC4, PART_FULL, COND_NEVER, COND_NEVER, ENTRY_BYTE};
         4'd4: w = '{SRC_CONST, LCD_NIB_LINES, PART_FULL, COND_NEVER, COND_ALWAYS, 4'd6};
         // Init on the 8-bit bus opens with function set.
         4'd5: w = '{SRC_CONST, LCD_FUNC_SET8, PART_FULL, COND_NEVER, COND_NEVER, ENTRY_BYTE};
         4'd6: w = '{SRC_CONST, LCD_DISPLAY_ON, PART_HEAD, COND_NEVER, COND_IF_8BIT, 4'd8};
         4'd7: w = '{SRC_CONST, LCD_DISPLAY_ON, PART_LOW, COND_NEVER, COND_NEVER, ENTRY_BYTE};
         4'd8: w = '{SRC_CONST, LCD_CLEAR, PART_HEAD, COND_IF_8BIT, COND_NEVER, ENTRY_BYTE};
         4'd9: w = '{SRC_CONST, LCD_CLEAR, PART_LOW, COND_ALWAYS, COND_NEVER, ENTRY_BYTE};
         default: w = '{SRC_CONST, 8'h00, PART_FULL, COND_ALWAYS, COND_NEVER, ENTRY_BYTE};
      endcase
      return w;
   endfunction

endpackage

@@ sv/char_lcd_bus_write_sequencer.sv @@
// Character LCD bus write sequencer: turns requests into enable-strobe bus writes.
//
// The req_ channel takes one item per request: an instruction byte, a data byte,
// a cursor position, or a power-on init. The rsp_ channel gives one item per bus
// strobe, with rsp_tlast high on the final strobe of the request. In 8-bit bus mode
// a byte is one strobe; in 4-bit mode it is two strobes, high nibble first, with the
// nibble in bits 3..0 of bus_value. Init gives 3 strobes in 8-bit mode and 7 in
// 4-bit mode (raw nibbles 2, 2, 8 first).
// A request occupies the block from its acceptance until its final strobe is issued.
// Acceptance loads the step counter; a microcode ROM of ten steps, indexed by the
// step counter, with conditional jumps on the bus mode, then gives one strobe per
// cycle into the output register, whenever it is empty or rsp_tready is high.
// The output register lets a new request be accepted while the final strobe of the
// previous one still waits on rsp_tready. A stalled receiver holds the step counter.
// Reset (synchronous, active high) empties the output register, idles the
// sequencer and sets both bus_mode and drive_rw to 1. Configuration writes are
// applied at once and must only happen while the block is idle.
module char_lcd_bus_write_sequencer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // command[1:0], byte_value[9:2], column[15:10], row[16]
   // strobe channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // reg_select[0], rw_low[1], bus_value[9:2]
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic        csr_wdata
);

   // Request fields.
   logic [1:0] req_command;
   logic [7:0] req_byte_value;
   logic [clcd_pkg::COL_W-1:0] req_column;
   logic       req_row;
   logic [clcd_pkg::COL_W-1:0] col_sat;
   logic [7:0] req_operand;

   assign req_command    = req_tdata[1:0];
   assign req_byte_value = req_tdata[9:2];
   assign req_column     = req_tdata[15:10];
   assign req_row        = req_tdata[16];

   // Configuration registers.
   logic bus_mode_ff, bus_mode_in;
   logic drive_rw_ff, drive_rw_in;

   // Sequencer state.
   logic                              busy_ff, busy_in;
   logic [clcd_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [7:0]                        oper_ff, oper_in;
   logic                              oper_rs_ff, oper_rs_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_rs_ff, rsp_rs_in;
   logic       rsp_rw_ff, rsp_rw_in;
   logic [7:0] rsp_bus_ff, rsp_bus_in;
   logic       rsp_last_ff, rsp_last_in;

   clcd_pkg::ctrl_word_type word;
   logic       req_accept;
   logic       can_emit;
   logic [7:0] byte_sel;
   logic [7:0] bus_val;
   logic       is_last;
   logic       take_jump;
   logic [clcd_pkg::STEP_W-1:0] entry;

   assign req_tready = !busy_ff;
   assign req_accept = req_tvalid && !busy_ff;

   // The cursor address is 0x80 | (row ? 0x40 : 0) | column, with the column clamped.
   assign col_sat = (req_column >= clcd_pkg::COL_MAX) ? clcd_pkg::COL_MAX : req_column;
   assign req_operand = (req_command == clcd_pkg::CMD_CURSOR) ?
                        {1'b1, req_row, col_sat} : req_byte_value;

   always_comb begin
      if (req_command != clcd_pkg::CMD_INIT) begin
         entry = clcd_pkg::ENTRY_BYTE;
      end else if (bus_mode_ff) begin
         entry = clcd_pkg::ENTRY_INIT4;
      end else begin
         entry = clcd_pkg::ENTRY_INIT8;
      end
   end

   // One control word per step.
   assign word     = clcd_pkg::ctrl_rom(step_ff);
   assign can_emit = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign byte_sel = (word.src == clcd_pkg::SRC_OPER) ? oper_ff : word.konst;

   always_comb begin
      case (word.part)
         clcd_pkg::PART_FULL: bus_val = byte_sel;
         clcd_pkg::PART_HEAD: bus_val = bus_mode_ff ? {4'h0, byte_sel[7:4]} : byte_sel;
         clcd_pkg::PART_LOW:  bus_val = {4'h0, byte_sel[3:0]};
         default:             bus_val = byte_sel;
      endcase
   end

   always_comb begin
      case (word.last_cond)
         clcd_pkg::COND_ALWAYS:  is_last = 1'b1;
         clcd_pkg::COND_IF_8BIT: is_last = !bus_mode_ff;
         default:                is_last = 1'b0;
      endcase
      case (word.jump_cond)
         clcd_pkg::COND_ALWAYS:  take_jump = 1'b1;
         clcd_pkg::COND_IF_8BIT: take_jump = !bus_mode_ff;
         default:                take_jump = 1'b0;
      endcase
   end

   // Next-state logic.
   always_comb begin
      bus_mode_in = bus_mode_ff;
      drive_rw_in = drive_rw_ff;
      if (csr_we) begin
         case (csr_index)
            clcd_pkg::REG_BUS_MODE: bus_mode_in = csr_wdata;
            clcd_pkg::REG_DRIVE_RW: drive_rw_in = csr_wdata;
            default: ;
         endcase
      end

      busy_in    = busy_ff;
      step_in    = step_ff;
      oper_in    = oper_ff;
      oper_rs_in = oper_rs_ff;
      if (req_accept) begin
         busy_in    = 1'b1;
         step_in    = entry;
         oper_in    = req_operand;
         oper_rs_in = (req_command == clcd_pkg::CMD_DATA);
      end else if (can_emit) begin
         busy_in = !is_last;
         step_in = take_jump ? word.target : step_ff + clcd_pkg::STEP_W'(1);
      end

      // The output register loads a strobe or drains when the receiver takes it.
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_rs_in    = rsp_rs_ff;
      rsp_rw_in    = rsp_rw_ff;
      rsp_bus_in   = rsp_bus_ff;
      rsp_last_in  = rsp_last_ff;
      if (can_emit) begin
         rsp_valid_in = 1'b1;
         rsp_rs_in    = (word.src == clcd_pkg::SRC_OPER) ? oper_rs_ff : 1'b0;
         rsp_rw_in    = drive_rw_ff;
         rsp_bus_in   = bus_val;
         rsp_last_in  = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_mode_ff  <= 1'b1;
         drive_rw_ff  <= 1'b1;
         busy_ff      <= 1'b0;
         step_ff      <= clcd_pkg::ENTRY_BYTE;
         rsp_valid_ff <= 1'b0;
      end else begin
         bus_mode_ff  <= bus_mode_in;
         drive_rw_ff  <= drive_rw_in;
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      oper_ff     <= oper_in;
      oper_rs_ff  <= oper_rs_in;
      rsp_rs_ff   <= rsp_rs_in;
      rsp_rw_ff   <= rsp_rw_in;
      rsp_bus_ff  <= rsp_bus_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'h00, rsp_bus_ff, rsp_rw_ff, rsp_rs_ff};
   assign rsp_tlast  = rsp_last_ff;

   // The step counter never leaves the program while a request is in progress.
   a_step_in_program: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= clcd_pkg::STEP_LAST))
      else $error("step counter outside the microcode program");

   // An accepted request starts the sequencer at a valid entry point.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (busy_ff && (step_ff == clcd_pkg::ENTRY_BYTE ||
                      step_ff == clcd_pkg::ENTRY_INIT4 || step_ff == clcd_pkg::ENTRY_INIT8)))
      else $error("request accepted without starting the sequencer");

   // Issuing the final strobe frees the sequencer and marks the item as last.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (can_emit && is_last) |=> (!busy_ff && rsp_tvalid && rsp_tlast))
      else $error("final strobe did not end the request");

   // A strobe that is not the last keeps the sequencer busy.
   a_not_last_continues: assert property (@(posedge clock) disable iff (reset)
      (can_emit && !is_last) |=> (busy_ff && rsp_tvalid && !rsp_tlast))
      else $error("sequencer stopped before the final strobe");

endmodule
